[hw/rtl/quadrature_position_velocity_unit_defines.svh]
// Assertion helpers shared by the decoder modules.
// Each expects clk and rst in the scope where it is used.
`ifndef QUADRATURE_POSITION_VELOCITY_UNIT_DEFINES_SVH
`define QUADRATURE_POSITION_VELOCITY_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QPV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QPV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qpv_pkg.sv]
`timescale 1ns / 1ps

package qpv_pkg;

  // Raw counter width and output fraction bits
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned PPR_W   = 14;
  localparam int unsigned CPR_W   = PPR_W + 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SCALE   = 1000000;
  localparam int unsigned NUM_W   = VAL_W + $clog2(SCALE + 1);
  localparam int unsigned DEN_W   = CPR_W + TIME_W;
  localparam int unsigned NFULL_W = NUM_W + FRAC_BITS + 1;
  // Quotient bits kept: the output width plus a rounding bit below
  localparam int unsigned QB      = VAL_W + 1;
  localparam int unsigned QCNT_W  = $clog2(QB + 1);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [VAL_W-1:0]      word_t;
  typedef logic [PPR_W-1:0]      ppr_t;
  typedef logic [CPR_W-1:0]      cpr_t;
  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [NUM_W-1:0]      num_t;
  typedef logic [DEN_W-1:0]      den_t;
  typedef logic [NFULL_W-1:0]    nfull_t;
  typedef logic [QB-1:0]         quo_t;
  typedef logic [QCNT_W-1:0]     qcnt_t;
  typedef logic [FIFO_AW-1:0]    fptr_t;
  typedef logic [FIFO_AW:0]      fcnt_t;

  localparam ppr_t PPR_RESET = ppr_t'(1024);
  localparam num_t SCALE_K   = num_t'(SCALE);

  // Request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // Saturation limits on the rounded magnitude
  localparam quo_t  SAT_NEG_MAG = quo_t'(1) << (VAL_W - 1);
  localparam quo_t  SAT_POS_MAG = SAT_NEG_MAG - quo_t'(1);
  localparam word_t VAL_MIN     = word_t'(SAT_NEG_MAG);
  localparam word_t VAL_MAX     = word_t'(SAT_POS_MAG);

  typedef struct packed {
    logic   is_update;
    logic   step_error;
    count_t count;
    time_t  now_us;
  } cmd_t;

  typedef struct packed {
    logic we;
    cmd_t cmd;
  } fifo_wr_t;

  typedef struct packed {
    word_t total_count;
    word_t position_rev;
    word_t velocity_rps;
    logic  step_error;
  } result_t;

  typedef struct packed {
    logic start;
    num_t num;
    den_t den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
    quo_t quo;
  } div_rsp_t;

endpackage

[hw/rtl/quadrature_position_velocity_unit.sv]
// Quadrature x4 decoder with position and velocity report.
// Input channel (push/full): one transaction per item. req_type 0 carries the
// A/B levels of a sample; req_type 1 is an update that carries now_us.
// Result channel (empty/pop): every item yields exactly one result, in order:
// total_count, position_rev and velocity_rps as of the last update, and
// step_error for a sample that flipped both channels at once.
// Config: cfg_we/cfg_wdata write pulses_per_rev; write it only while idle.
// Front decodes levels into the raw count as items arrive, at one item per cycle
// while the queue is not full, and queues a command (4 deep) for the back end.
// Samples: result via the command queue and the result register, one per cycle
// sustained while the receiver pops and no update is in progress. Updates run
// the divider for position, then velocity; velocity is skipped on zero elapsed
// time, both on zero pulses_per_rev; a saturating quotient ends its divide early.
// The shared divider retires one of 33 quotient bits per cycle; later items wait.
// When the receiver stalls, the result register holds and the command queue
// absorbs up to 4 more items before full rises.
// Reset (rst, synchronous) clears all counts, times, position and velocity,
// empties the queues and sets pulses_per_rev to 1024. No clearing pass.
`timescale 1ns / 1ps

module quadrature_position_velocity_unit (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic [13:0]        cfg_wdata,
  // input transactions
  input  logic               push,
  output logic               full,
  input  logic               req_type,
  input  logic               level_a,
  input  logic               level_b,
  input  logic [31:0]        now_us,
  // result transactions
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] total_count,
  output logic signed [31:0] position_rev,
  output logic signed [31:0] velocity_rps,
  output logic               step_error
);

  qpv_pkg::fifo_wr_t q_wr;
  qpv_pkg::cmd_t     q_head;
  logic              q_full;
  logic              q_empty;
  logic              q_rd;
  logic              out_valid;
  qpv_pkg::result_t  res;
  qpv_pkg::div_req_t div_req;
  qpv_pkg::div_rsp_t div_rsp;

  // Front: decode levels, keep the raw count, classify items
  qpv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (q_full),
    .req_type (req_type),
    .level_a  (level_a),
    .level_b  (level_b),
    .now_us   (now_us),
    .wr       (q_wr)
  );

  // Command queue between front and back
  qpv_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .rd    (q_rd),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // Shared bit-serial divider for position and velocity
  qpv_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Back: fold count changes, scale, saturate, hold the result register
  qpv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (q_head),
    .q_empty   (q_empty),
    .rd        (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .res       (res),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  assign full         = q_full;
  assign empty        = ~out_valid;
  assign total_count  = $signed(res.total_count);
  assign position_rev = $signed(res.position_rev);
  assign velocity_rps = $signed(res.velocity_rps);
  assign step_error   = res.step_error;

endmodule

[hw/rtl/qpv_front.sv]
`timescale 1ns / 1ps

module qpv_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              full,
  input  logic              req_type,
  input  logic              level_a,
  input  logic              level_b,
  input  qpv_pkg::time_t    now_us,
  output qpv_pkg::fifo_wr_t wr
);

  logic [1:0]       prev_levels;
  qpv_pkg::count_t  raw_count;
  logic             accept;
  logic             is_sample;
  logic             a_chg;
  logic             b_chg;
  logic             moved;
  logic             up;

  assign accept    = push & ~full;
  assign is_sample = (req_type == qpv_pkg::REQ_SAMPLE);
  assign a_chg     = level_a ^ prev_levels[1];
  assign b_chg     = level_b ^ prev_levels[0];
  assign moved     = a_chg ^ b_chg;

  // Direction of a single-channel step
  always_comb begin
    if (a_chg) begin
      up = level_a ? ~level_b : level_b;
    end else begin
      up = level_b ? level_a : ~level_a;
    end
  end

  always_comb begin
    wr.we             = accept;
    wr.cmd.is_update  = ~is_sample;
    wr.cmd.step_error = is_sample & a_chg & b_chg;
    wr.cmd.count      = raw_count;
    wr.cmd.now_us     = now_us;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
      raw_count   <= '0;
    end else if (accept && is_sample) begin
      prev_levels <= {level_a, level_b};
      if (moved) begin
        raw_count <= up ? raw_count + qpv_pkg::count_t'(1)
                        : raw_count - qpv_pkg::count_t'(1);
      end
    end
  end

endmodule

[hw/rtl/qpv_cmd_fifo.sv]
`timescale 1ns / 1ps
`include "quadrature_position_velocity_unit_defines.svh"

module qpv_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  qpv_pkg::fifo_wr_t wr,
  input  logic              rd,
  output qpv_pkg::cmd_t     head,
  output logic              full,
  output logic              empty
);

  qpv_pkg::cmd_t  entries [qpv_pkg::FIFO_DEPTH];
  qpv_pkg::fptr_t wr_ptr;
  qpv_pkg::fptr_t rd_ptr;
  qpv_pkg::fcnt_t count;
  logic           do_wr;
  logic           do_rd;

  assign full  = (count == qpv_pkg::fcnt_t'(qpv_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr.we & ~full;
  assign do_rd = rd & ~empty;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + qpv_pkg::fptr_t'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + qpv_pkg::fptr_t'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + qpv_pkg::fcnt_t'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - qpv_pkg::fcnt_t'(1);
      end
    end
  end

  `QPV_ASSERT_NEXT(a_fifo_grow, do_wr && !do_rd, count == $past(count) + qpv_pkg::fcnt_t'(1), "command queue lost a write")

endmodule

[hw/rtl/qpv_divider.sv]
`timescale 1ns / 1ps
`include "quadrature_position_velocity_unit_defines.svh"

module qpv_divider (
  input  logic              clk,
  input  logic              rst,
  input  qpv_pkg::div_req_t req,
  output qpv_pkg::div_rsp_t rsp
);

  qpv_pkg::nfull_t n_full;
  qpv_pkg::nfull_t n_high;
  logic            ovf_now;
  qpv_pkg::den_t   den;
  qpv_pkg::den_t   rem;
  qpv_pkg::quo_t   low;
  qpv_pkg::quo_t   quo;
  qpv_pkg::qcnt_t  cnt;
  logic            busy;
  logic            done;
  logic            done_next;
  logic            ovf;
  logic [qpv_pkg::DEN_W:0] shifted;
  logic            take;

  // Numerator scaled by 2^(FRAC_BITS+1); the extra bit feeds rounding
  assign n_full  = {req.num, {(qpv_pkg::FRAC_BITS + 1){1'b0}}};
  assign n_high  = n_full >> qpv_pkg::QB;
  // Quotient would not fit in QB bits: result saturates anyway
  assign ovf_now = (n_high >= qpv_pkg::nfull_t'(req.den));

  assign shifted = {rem, low[qpv_pkg::QB-1]};
  assign take    = (shifted >= {1'b0, den});

  // Pulse done on an overflowing start or on the last restoring step
  assign done_next = req.start ? ovf_now : (busy && (cnt == qpv_pkg::qcnt_t'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= done_next;
      if (req.start) begin
        ovf <= ovf_now;
        den <= req.den;
        rem <= qpv_pkg::den_t'(n_high);
        low <= n_full[qpv_pkg::QB-1:0];
        quo <= '0;
        if (!ovf_now) begin
          busy <= 1'b1;
          cnt  <= qpv_pkg::qcnt_t'(qpv_pkg::QB);
        end
      end else if (busy) begin
        // One restoring step per cycle
        if (take) begin
          rem <= qpv_pkg::den_t'(shifted - {1'b0, den});
        end else begin
          rem <= shifted[qpv_pkg::DEN_W-1:0];
        end
        quo <= {quo[qpv_pkg::QB-2:0], take};
        low <= low << 1;
        cnt <= cnt - qpv_pkg::qcnt_t'(1);
        if (cnt == qpv_pkg::qcnt_t'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    rsp.busy = busy;
    rsp.done = done;
    rsp.ovf  = ovf;
    rsp.quo  = quo;
  end

  `QPV_ASSERT_NEXT(a_div_launch, req.start && !busy && !ovf_now, busy && (cnt == qpv_pkg::qcnt_t'(qpv_pkg::QB)), "divider did not launch")

endmodule

[hw/rtl/qpv_back.sv]
`timescale 1ns / 1ps
`include "quadrature_position_velocity_unit_defines.svh"

module qpv_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  qpv_pkg::ppr_t     cfg_wdata,
  input  qpv_pkg::cmd_t     head,
  input  logic              q_empty,
  output logic              rd,
  input  logic              pop,
  output logic              out_valid,
  output qpv_pkg::result_t  res,
  output qpv_pkg::div_req_t div_req,
  input  qpv_pkg::div_rsp_t div_rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_MUL,
    S_POS,
    S_VEL,
    S_FINISH
  } state_t;

  state_t          state;
  qpv_pkg::ppr_t   ppr;
  qpv_pkg::cpr_t   cpr;
  qpv_pkg::word_t  cau;
  qpv_pkg::word_t  acc;
  qpv_pkg::time_t  tau;
  qpv_pkg::word_t  position;
  qpv_pkg::word_t  velocity;
  qpv_pkg::word_t  delta;
  qpv_pkg::word_t  dmag;
  qpv_pkg::time_t  dt;
  qpv_pkg::num_t   vnum;
  qpv_pkg::den_t   vden;
  logic            div_start;
  logic            div_start_next;
  qpv_pkg::num_t   div_num;
  qpv_pkg::den_t   div_den;
  logic            slot_free;
  logic            out_valid_next;

  function automatic qpv_pkg::word_t magnitude(qpv_pkg::word_t v);
    return v[qpv_pkg::VAL_W-1] ? qpv_pkg::word_t'(0) - v : v;
  endfunction

  // Round half away from zero on the magnitude, then clamp
  function automatic qpv_pkg::word_t saturate(logic neg, logic ovf, qpv_pkg::quo_t q);
    logic [qpv_pkg::QB:0] sum;
    qpv_pkg::quo_t        mag;
    sum = {1'b0, q} + {{qpv_pkg::QB{1'b0}}, 1'b1};
    mag = qpv_pkg::quo_t'(sum >> 1);
    if (neg) begin
      if (ovf || mag >= qpv_pkg::SAT_NEG_MAG) begin
        return qpv_pkg::VAL_MIN;
      end
      return qpv_pkg::word_t'(qpv_pkg::quo_t'(0) - mag);
    end
    if (ovf || mag >= qpv_pkg::SAT_POS_MAG) begin
      return qpv_pkg::VAL_MAX;
    end
    return qpv_pkg::word_t'(mag);
  endfunction

  assign cpr       = {ppr, 2'b00};
  assign slot_free = ~out_valid | pop;
  assign rd        = (state == S_IDLE) && !q_empty && (head.is_update || slot_free);

  // Launch the divider for position when pulses_per_rev is nonzero, then for velocity when time has passed
  assign div_start_next = ((state == S_MUL) && (ppr != '0)) ||
                          ((state == S_POS) && div_rsp.done && (dt != '0));

  // Load the result register on a sample read or a finished update
  always_comb begin
    out_valid_next = out_valid & ~pop;
    if ((rd && !head.is_update) || ((state == S_FINISH) && slot_free)) begin
      out_valid_next = 1'b1;
    end
  end

  always_comb begin
    div_req.start = div_start;
    div_req.num   = div_num;
    div_req.den   = div_den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      ppr       <= qpv_pkg::PPR_RESET;
      cau       <= '0;
      acc       <= '0;
      tau       <= '0;
      position  <= '0;
      velocity  <= '0;
    end else begin
      if (cfg_we) begin
        ppr <= cfg_wdata;
      end
      div_start <= div_start_next;
      out_valid <= out_valid_next;
      case (state)
        S_IDLE: begin
          if (rd) begin
            if (head.is_update) begin
              delta <= qpv_pkg::word_t'($signed(
                         qpv_pkg::count_t'(head.count - qpv_pkg::count_t'(cau))));
              dt    <= head.now_us - tau;
              cau   <= qpv_pkg::word_t'(head.count);
              tau   <= head.now_us;
              state <= S_ACC;
            end else begin
              res.total_count  <= acc;
              res.position_rev <= position;
              res.velocity_rps <= velocity;
              res.step_error   <= head.step_error;
            end
          end
        end
        S_ACC: begin
          acc   <= acc + delta;
          dmag  <= magnitude(delta);
          state <= S_MUL;
        end
        S_MUL: begin
          vnum    <= qpv_pkg::num_t'(dmag) * qpv_pkg::SCALE_K;
          vden    <= qpv_pkg::den_t'(cpr) * qpv_pkg::den_t'(dt);
          div_num <= qpv_pkg::num_t'(magnitude(acc));
          div_den <= qpv_pkg::den_t'(cpr);
          if (ppr == '0) begin
            position <= '0;
            velocity <= '0;
            state    <= S_FINISH;
          end else begin
            state <= S_POS;
          end
        end
        S_POS: begin
          if (div_rsp.done) begin
            position <= saturate(acc[qpv_pkg::VAL_W-1], div_rsp.ovf, div_rsp.quo);
            if (dt != '0) begin
              div_num <= vnum;
              div_den <= vden;
              state   <= S_VEL;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_VEL: begin
          if (div_rsp.done) begin
            velocity <= saturate(delta[qpv_pkg::VAL_W-1], div_rsp.ovf, div_rsp.quo);
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            res.total_count  <= acc;
            res.position_rev <= position;
            res.velocity_rps <= velocity;
            res.step_error   <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `QPV_ASSERT_SAME(a_div_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `QPV_ASSERT_NEXT(a_sample_out, rd && !head.is_update, out_valid && (res.step_error == $past(head.step_error)), "sample result not loaded")
  `QPV_ASSERT_SAME(a_no_read_busy, rd, state == S_IDLE, "command read outside idle")

endmodule
